// ===== src/rmast_pkg.sv =====
`timescale 1ns / 1ps
// Package for the range multiply/add/sum segment tree.
// Holds the sizes, codes and shared types used by all modules in src.
package rmast_pkg;

  localparam int MAX_LENGTH  = 1024;
  localparam int NODE_COUNT  = 4096;

  localparam int VAL_W       = 31;
  localparam int POS_W       = $clog2(MAX_LENGTH + 1);
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int FUNC_W      = 2;

  localparam int STACK_DEPTH = $clog2(MAX_LENGTH) + 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;

  // Modular multiply unit: a 64-bit dividend reduced two bits per step.
  localparam int DVD_W       = 64;
  localparam int MMU_BITS    = 2;
  localparam int MMU_STEPS   = DVD_W / MMU_BITS;
  localparam int STEP_W      = $clog2(MMU_STEPS);

  localparam logic [VAL_W-1:0] MOD_RESET = 31'h7FFF_FFFF;
  localparam logic [POS_W-1:0] LEN_RESET = POS_W'(MAX_LENGTH);

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_MUL = 2'd0,
    FN_ADD = 2'd1,
    FN_SUM = 2'd2,
    FN_NOP = 2'd3
  } func_t;

  typedef struct packed {
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] mul;
    logic [VAL_W-1:0] add;
  } node_word_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    node_word_t        data;
  } ram_wr_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] c;
  } mmu_req_t;

endpackage

// ===== src/rmast_ram.sv =====
`timescale 1ns / 1ps
// Node store of the segment tree: one write port, one registered read port.
// Depends on rmast_pkg for the node word layout and the depth.
module rmast_ram (
  input  logic                      clk,
  input  rmast_pkg::ram_wr_t        wr,
  input  logic [rmast_pkg::NODE_W-1:0] raddr,
  output rmast_pkg::node_word_t     rdata
);
  import rmast_pkg::*;

  node_word_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rmast_mmu.sv =====
`timescale 1ns / 1ps
// Shared modular multiply-add unit: computes (a*b + c) mod m.
// A multiply, a load of the dividend, then restoring reduction; uses rmast_pkg.
module rmast_mmu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rmast_pkg::mmu_req_t      req,
  input  logic [rmast_pkg::VAL_W-1:0] modulus,
  output logic                     done,
  output logic [rmast_pkg::VAL_W-1:0] res
);
  import rmast_pkg::*;

  typedef enum logic [2:0] {
    MP_IDLE = 3'b001,
    MP_LOAD = 3'b010,
    MP_DIV  = 3'b100
  } mphase_t;

  mphase_t               phase_r;
  logic [2*VAL_W-1:0]    prod_r;
  logic [VAL_W-1:0]      c_r;
  logic [DVD_W-1:0]      dvd_r;
  logic [VAL_W:0]        rem_r;
  logic [STEP_W-1:0]     cnt_r;
  logic                  done_r;

  logic [DVD_W-1:0]      dvd_nxt;
  logic [VAL_W:0]        rem_nxt;

  // Restoring steps for MMU_BITS dividend bits at a time; the remainder stays below the modulus.
  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int j = 0; j < MMU_BITS; j++) begin
      rem_nxt = {rem_nxt[VAL_W-1:0], dvd_nxt[DVD_W-1]};
      dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, modulus}) begin
        rem_nxt = rem_nxt - {1'b0, modulus};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        MP_IDLE: begin
          if (req.start) begin
            phase_r <= MP_LOAD;
          end
        end
        MP_LOAD: begin
          cnt_r   <= '0;
          phase_r <= MP_DIV;
        end
        MP_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == STEP_W'(MMU_STEPS - 1)) begin
            done_r  <= 1'b1;
            phase_r <= MP_IDLE;
          end
        end
        default: phase_r <= MP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      MP_IDLE: begin
        prod_r <= (2*VAL_W)'(req.a) * (2*VAL_W)'(req.b);
        c_r    <= req.c;
      end
      MP_LOAD: begin
        dvd_r <= DVD_W'(prod_r) + DVD_W'(c_r);
        rem_r <= '0;
      end
      MP_DIV: begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign done = done_r;
  assign res  = rem_r[VAL_W-1:0];

endmodule

// ===== src/range_mul_add_sum_mod_tree.sv =====
`timescale 1ns / 1ps
// Top level of the range multiply/add/sum segment tree with lazy tags.
// Uses rmast_pkg, the node store rmast_ram and the modular unit rmast_mmu.
//
// Usage: raise start with an item on in_func/in_left/in_right/in_value; the
// item is taken on a clock edge where start is high and busy is low. Range
// multiply (func 0) and range add (func 1) give no result; a sum query (func 2)
// gives exactly one result on out_sum, marked by out_valid for a single cycle
// when the item completes. The receiver cannot stall that transfer, so it must
// capture out_sum whenever out_valid is high. Items with an empty or
// out-of-range interval are dropped, except that a query on one answers 0 in
// the cycle after it is taken; func 3 is dropped. The tree walk is driven by a
// sequencer around one shared modular multiply-add unit, which works through a
// multiply, a load and 32 reduction steps of two bits per operation. Each node
// update costs four such operations plus a read and a write of the node. A
// query pays for each visited node and for each lazy push, which updates both
// children; an update also pays for every covered node and for the value
// reduction. Items may span up to the full length of 1024; an item's work is
// bounded by the number of nodes on the two boundary paths. After reset, and
// after every configuration write, the node store is swept clear, all 4096
// nodes, with busy high. Configuration writes on cfg_we/cfg_index/cfg_data are
// taken at once and must only be issued while busy is low.
module range_mul_add_sum_mod_tree (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rmast_pkg::FUNC_W-1:0]      in_func,
  input  logic [rmast_pkg::POS_W-1:0]       in_left,
  input  logic [rmast_pkg::POS_W-1:0]       in_right,
  input  logic [rmast_pkg::VAL_W-1:0]       in_value,
  output logic                              out_valid,
  output logic [rmast_pkg::VAL_W-1:0]       out_sum,
  input  logic                              cfg_we,
  input  logic [rmast_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmast_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rmast_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR   = 20'h00001,
    S_IDLE    = 20'h00002,
    S_KRED    = 20'h00004,
    S_VISIT   = 20'h00008,
    S_QACC    = 20'h00010,
    S_PDLOAD  = 20'h00020,
    S_PDRIGHT = 20'h00040,
    S_PDCLR   = 20'h00080,
    S_DESCEND = 20'h00100,
    S_RIGHT   = 20'h00200,
    S_FINISH  = 20'h00400,
    S_PU1     = 20'h00800,
    S_PU2     = 20'h01000,
    S_POP     = 20'h02000,
    S_AREAD   = 20'h04000,
    S_ALOAD   = 20'h08000,
    S_AOP1    = 20'h10000,
    S_AOP2    = 20'h20000,
    S_AOP3    = 20'h40000,
    S_AOP4    = 20'h80000
  } state_t;

  // Control state.
  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [NODE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  mod_r, mod_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;

  // Item and walk payload.
  func_t             func_r, func_nxt;
  logic [POS_W-1:0]  ql_r, ql_nxt, qr_r, qr_nxt;
  logic [VAL_W-1:0]  mv_r, mv_nxt, av_r, av_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [VAL_W-1:0]  out_sum_r, out_sum_nxt;
  logic [NODE_W-1:0] cur_o_r, cur_o_nxt;
  logic [POS_W-1:0]  cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [NODE_W-1:0] ap_node_r, ap_node_nxt;
  logic [POS_W-1:0]  ap_len_r, ap_len_nxt;
  logic [VAL_W-1:0]  ap_mv_r, ap_mv_nxt, ap_av_r, ap_av_nxt;
  logic [VAL_W-1:0]  nd_sum_r, nd_sum_nxt, nd_mul_r, nd_mul_nxt, nd_add_r, nd_add_nxt;
  logic [VAL_W-1:0]  sum_new_r, sum_new_nxt, mul_new_r, mul_new_nxt;
  logic [VAL_W-1:0]  hold_sum_r, hold_sum_nxt;

  // Frame stack of parent nodes on the current path.
  logic [NODE_W-1:0] stk_node_r [STACK_DEPTH];
  logic [POS_W-1:0]  stk_lo_r   [STACK_DEPTH];
  logic [POS_W-1:0]  stk_hi_r   [STACK_DEPTH];
  logic              stk_fin_r  [STACK_DEPTH];
  logic              stk_push;
  logic              stk_fin_in;
  logic [SP_W-1:0]   sp_top;

  // Memory and arithmetic unit hookup.
  ram_wr_t           ram_wr;
  logic [NODE_W-1:0] ram_raddr;
  node_word_t        ram_rdata;
  mmu_req_t          mmu_req;
  logic              mmu_done;
  logic [VAL_W-1:0]  mmu_res;

  // Derived values.
  logic [VAL_W-1:0]  cur_mod;
  logic [POS_W-1:0]  cur_len;
  logic [POS_W:0]    lh_sum;
  logic [POS_W-1:0]  mid;
  logic              covered;
  logic              in_ok;
  logic [NODE_W-1:0] child_l, child_r;
  logic [VAL_W:0]    madd_in_a, madd_in_b, madd_raw;
  logic [VAL_W-1:0]  madd_out;

  rmast_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmast_mmu u_mmu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mmu_req),
    .modulus (cur_mod),
    .done    (mmu_done),
    .res     (mmu_res)
  );

  // A modulus below two behaves as two; the length is clamped to [1, MAX_LENGTH].
  assign cur_mod = (mod_r < VAL_W'(2)) ? VAL_W'(2) : mod_r;
  always_comb begin
    if (len_r == '0) begin
      cur_len = POS_W'(1);
    end else if (len_r > POS_W'(MAX_LENGTH)) begin
      cur_len = POS_W'(MAX_LENGTH);
    end else begin
      cur_len = len_r;
    end
  end

  assign lh_sum  = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign mid     = lh_sum[POS_W:1];
  assign covered = (ql_r <= cur_lo_r) && (cur_hi_r <= qr_r);
  assign child_l = {cur_o_r[NODE_W-2:0], 1'b0};
  assign child_r = {cur_o_r[NODE_W-2:0], 1'b1};
  assign in_ok   = (in_left != '0) && (in_right <= cur_len) && (in_left <= in_right);
  assign sp_top  = sp_r - 1'b1;

  // Modular add of two reduced values: the sum is below twice the modulus.
  assign madd_raw = madd_in_a + madd_in_b;
  assign madd_out = (madd_raw >= {1'b0, cur_mod}) ?
                    VAL_W'(madd_raw - {1'b0, cur_mod}) : madd_raw[VAL_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    sp_nxt        = sp_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    mod_nxt       = mod_r;
    len_nxt       = len_r;
    func_nxt      = func_r;
    ql_nxt        = ql_r;
    qr_nxt        = qr_r;
    mv_nxt        = mv_r;
    av_nxt        = av_r;
    acc_nxt       = acc_r;
    cur_o_nxt     = cur_o_r;
    cur_lo_nxt    = cur_lo_r;
    cur_hi_nxt    = cur_hi_r;
    ap_node_nxt   = ap_node_r;
    ap_len_nxt    = ap_len_r;
    ap_mv_nxt     = ap_mv_r;
    ap_av_nxt     = ap_av_r;
    nd_sum_nxt    = nd_sum_r;
    nd_mul_nxt    = nd_mul_r;
    nd_add_nxt    = nd_add_r;
    sum_new_nxt   = sum_new_r;
    mul_new_nxt   = mul_new_r;
    hold_sum_nxt  = hold_sum_r;
    stk_push      = 1'b0;
    stk_fin_in    = 1'b0;
    ram_wr        = '0;
    ram_raddr     = cur_o_r;
    mmu_req       = '0;
    madd_in_a     = {1'b0, acc_r};
    madd_in_b     = {1'b0, ram_rdata.sum};

    case (state_r)
      S_CLEAR: begin
        ram_wr.we       = 1'b1;
        ram_wr.addr     = clr_cnt_r;
        ram_wr.data.sum = '0;
        ram_wr.data.mul = VAL_W'(1);
        ram_wr.data.add = '0;
        clr_cnt_nxt     = clr_cnt_r + 1'b1;
        if (clr_cnt_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mmu_req.a = in_value;
        mmu_req.b = VAL_W'(1);
        if (start) begin
          func_nxt   = func_t'(in_func);
          ql_nxt     = in_left;
          qr_nxt     = in_right;
          acc_nxt    = '0;
          sp_nxt     = '0;
          cur_o_nxt  = NODE_W'(1);
          cur_lo_nxt = POS_W'(1);
          cur_hi_nxt = cur_len;
          case (func_t'(in_func))
            FN_MUL, FN_ADD: begin
              if (in_ok) begin
                mmu_req.start = 1'b1;
                state_nxt     = S_KRED;
              end
            end
            FN_SUM: begin
              if (in_ok) begin
                state_nxt = S_VISIT;
              end else begin
                out_valid_nxt = 1'b1;
                out_sum_nxt   = '0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_KRED: begin
        // The operand is reduced once; multiply and add then share one walk.
        if (mmu_done) begin
          if (func_r == FN_MUL) begin
            mv_nxt = mmu_res;
            av_nxt = '0;
          end else begin
            mv_nxt = VAL_W'(1);
            av_nxt = mmu_res;
          end
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        if (covered && func_r == FN_SUM) begin
          state_nxt = S_QACC;
        end else if (covered) begin
          ap_node_nxt = cur_o_r;
          ap_len_nxt  = POS_W'(cur_hi_r - cur_lo_r + 1'b1);
          ap_mv_nxt   = mv_r;
          ap_av_nxt   = av_r;
          ret_nxt     = S_POP;
          state_nxt   = S_AREAD;
        end else begin
          state_nxt = S_PDLOAD;
        end
      end
      S_QACC: begin
        acc_nxt   = madd_out;
        state_nxt = S_POP;
      end
      S_PDLOAD: begin
        // Identity tags need no push to the children.
        hold_sum_nxt = ram_rdata.sum;
        if (ram_rdata.mul == VAL_W'(1) && ram_rdata.add == '0) begin
          state_nxt = S_DESCEND;
        end else begin
          ap_node_nxt = child_l;
          ap_len_nxt  = POS_W'(mid - cur_lo_r + 1'b1);
          ap_mv_nxt   = ram_rdata.mul;
          ap_av_nxt   = ram_rdata.add;
          ret_nxt     = S_PDRIGHT;
          state_nxt   = S_AREAD;
        end
      end
      S_PDRIGHT: begin
        ap_node_nxt = child_r;
        ap_len_nxt  = POS_W'(cur_hi_r - mid);
        ret_nxt     = S_PDCLR;
        state_nxt   = S_AREAD;
      end
      S_PDCLR: begin
        ram_wr.we       = 1'b1;
        ram_wr.addr     = cur_o_r;
        ram_wr.data.sum = hold_sum_r;
        ram_wr.data.mul = VAL_W'(1);
        ram_wr.data.add = '0;
        state_nxt       = S_DESCEND;
      end
      S_DESCEND: begin
        if (ql_r <= mid) begin
          stk_push   = 1'b1;
          stk_fin_in = 1'b0;
          sp_nxt     = sp_r + 1'b1;
          cur_o_nxt  = child_l;
          cur_hi_nxt = mid;
          state_nxt  = S_VISIT;
        end else begin
          state_nxt = S_RIGHT;
        end
      end
      S_RIGHT: begin
        if (qr_r > mid) begin
          stk_push   = 1'b1;
          stk_fin_in = 1'b1;
          sp_nxt     = sp_r + 1'b1;
          cur_o_nxt  = child_r;
          cur_lo_nxt = POS_W'(mid + 1'b1);
          state_nxt  = S_VISIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (func_r == FN_SUM) begin
          state_nxt = S_POP;
        end else begin
          ram_raddr = child_l;
          state_nxt = S_PU1;
        end
      end
      S_PU1: begin
        hold_sum_nxt = ram_rdata.sum;
        ram_raddr    = child_r;
        state_nxt    = S_PU2;
      end
      S_PU2: begin
        // Tags of a node that was walked through are already the identity.
        madd_in_a       = {1'b0, hold_sum_r};
        ram_wr.we       = 1'b1;
        ram_wr.addr     = cur_o_r;
        ram_wr.data.sum = madd_out;
        ram_wr.data.mul = VAL_W'(1);
        ram_wr.data.add = '0;
        state_nxt       = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          if (func_r == FN_SUM) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = acc_r;
          end
          state_nxt = S_IDLE;
        end else begin
          sp_nxt     = sp_top;
          cur_o_nxt  = stk_node_r[sp_top[STK_IDX_W-1:0]];
          cur_lo_nxt = stk_lo_r[sp_top[STK_IDX_W-1:0]];
          cur_hi_nxt = stk_hi_r[sp_top[STK_IDX_W-1:0]];
          state_nxt  = stk_fin_r[sp_top[STK_IDX_W-1:0]] ? S_FINISH : S_RIGHT;
        end
      end
      S_AREAD: begin
        ram_raddr = ap_node_r;
        state_nxt = S_ALOAD;
      end
      S_ALOAD: begin
        // First the addend scaled by the node length.
        nd_sum_nxt    = ram_rdata.sum;
        nd_mul_nxt    = ram_rdata.mul;
        nd_add_nxt    = ram_rdata.add;
        mmu_req.start = 1'b1;
        mmu_req.a     = ap_av_r;
        mmu_req.b     = VAL_W'(ap_len_r);
        state_nxt     = S_AOP1;
      end
      S_AOP1: begin
        mmu_req.a = nd_sum_r;
        mmu_req.b = ap_mv_r;
        mmu_req.c = mmu_res;
        if (mmu_done) begin
          mmu_req.start = 1'b1;
          state_nxt     = S_AOP2;
        end
      end
      S_AOP2: begin
        mmu_req.a = nd_mul_r;
        mmu_req.b = ap_mv_r;
        if (mmu_done) begin
          sum_new_nxt   = mmu_res;
          mmu_req.start = 1'b1;
          state_nxt     = S_AOP3;
        end
      end
      S_AOP3: begin
        mmu_req.a = nd_add_r;
        mmu_req.b = ap_mv_r;
        mmu_req.c = ap_av_r;
        if (mmu_done) begin
          mul_new_nxt   = mmu_res;
          mmu_req.start = 1'b1;
          state_nxt     = S_AOP4;
        end
      end
      S_AOP4: begin
        if (mmu_done) begin
          ram_wr.we       = 1'b1;
          ram_wr.addr     = ap_node_r;
          ram_wr.data.sum = sum_new_r;
          ram_wr.data.mul = mul_new_r;
          ram_wr.data.add = mmu_res;
          state_nxt       = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Any register write rebuilds the tree from its reset contents.
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS: mod_nxt = cfg_data[VAL_W-1:0];
        CFG_LENGTH:  len_nxt = cfg_data[POS_W-1:0];
        default:     mod_nxt = mod_r;
      endcase
      clr_cnt_nxt = '0;
      state_nxt   = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_POP;
      sp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET;
      len_r       <= LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      sp_r        <= sp_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mod_r       <= mod_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    ql_r       <= ql_nxt;
    qr_r       <= qr_nxt;
    mv_r       <= mv_nxt;
    av_r       <= av_nxt;
    acc_r      <= acc_nxt;
    out_sum_r  <= out_sum_nxt;
    cur_o_r    <= cur_o_nxt;
    cur_lo_r   <= cur_lo_nxt;
    cur_hi_r   <= cur_hi_nxt;
    ap_node_r  <= ap_node_nxt;
    ap_len_r   <= ap_len_nxt;
    ap_mv_r    <= ap_mv_nxt;
    ap_av_r    <= ap_av_nxt;
    nd_sum_r   <= nd_sum_nxt;
    nd_mul_r   <= nd_mul_nxt;
    nd_add_r   <= nd_add_nxt;
    sum_new_r  <= sum_new_nxt;
    mul_new_r  <= mul_new_nxt;
    hold_sum_r <= hold_sum_nxt;
    if (stk_push) begin
      stk_node_r[sp_r[STK_IDX_W-1:0]] <= cur_o_r;
      stk_lo_r[sp_r[STK_IDX_W-1:0]]   <= cur_lo_r;
      stk_hi_r[sp_r[STK_IDX_W-1:0]]   <= cur_hi_r;
      stk_fin_r[sp_r[STK_IDX_W-1:0]]  <= stk_fin_in;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

endmodule
